/* rtl/ptok_pkg.sv */
// Package: shared constants, item type, character classes and control structs for the tokenizer.
`default_nettype none
package ptok_pkg;

    localparam int SPACE_BUF_DEPTH_DEF = 16;
    localparam int MAX_NEST_DEF        = 255;
    localparam int LINE_BITS_DEF       = 24;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;

    localparam logic [3:0] K_IDENT   = 4'd0;
    localparam logic [3:0] K_NUMBER  = 4'd1;
    localparam logic [3:0] K_FLOAT   = 4'd2;
    localparam logic [3:0] K_STRING  = 4'd3;
    localparam logic [3:0] K_COMMENT = 4'd4;
    localparam logic [3:0] K_DOT     = 4'd5;
    localparam logic [3:0] K_LPAREN  = 4'd6;
    localparam logic [3:0] K_RPAREN  = 4'd7;
    localparam logic [3:0] K_COLON   = 4'd8;
    localparam logic [3:0] K_END     = 4'd9;
    localparam logic [3:0] K_NONE    = 4'd15;

    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_OPEN_CMT  = 3'd1;
    localparam logic [2:0] E_OPEN_STR  = 3'd2;
    localparam logic [2:0] E_BAD_CHAR  = 3'd3;
    localparam logic [2:0] E_TOO_LARGE = 3'd4;
    localparam logic [2:0] E_LIMIT     = 3'd5;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  ch;
        logic        has;
        logic        first;
        logic        last;
        logic [23:0] line;
        logic [62:0] value;
        logic [2:0]  err;
    } t_item;

    typedef struct packed {
        logic accept;
        logic step;
        logic flush_emit;
        logic float2;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic emits;
        logic again;
        logic float2;
        logic flush;
        logic flush_last;
        logic can_emit;
    } t_stat;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_upper(logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_trim_space(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return is_trim_space(c) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic t_item mk_item(logic [3:0] kind, logic [7:0] ch, logic has,
                                      logic first, logic last, logic [23:0] line,
                                      logic [62:0] value, logic [2:0] err);
        t_item it;
        it.kind  = kind;
        it.ch    = ch;
        it.has   = has;
        it.first = first;
        it.last  = last;
        it.line  = line;
        it.value = value;
        it.err   = err;
        return it;
    endfunction

endpackage
`default_nettype wire

/* rtl/ptok_if.sv */
// Interfaces: source byte channel, token item channel and configuration write channel.
`default_nettype none
interface ptok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_source;
    modport source (output valid, output char_in, output end_of_source, input ready);
    modport sink   (input valid, input char_in, input end_of_source, output ready);
endinterface

interface ptok_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  text_char;
    logic        has_char;
    logic        token_first;
    logic        token_last;
    logic [23:0] token_line;
    logic [62:0] number_value;
    logic [2:0]  error_code;
    logic        run_last;
    modport source (output valid, output token_kind, output text_char, output has_char,
                    output token_first, output token_last, output token_line,
                    output number_value, output error_code, output run_last, input ready);
    modport sink   (input valid, input token_kind, input text_char, input has_char,
                    input token_first, input token_last, input token_line,
                    input number_value, input error_code, input run_last, output ready);
endinterface

interface ptok_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] first_line;
    modport source (output valid, output first_line, input ready);
    modport sink   (input valid, input first_line, output ready);
endinterface
`default_nettype wire

/* rtl/ptok_dp.sv */
// Datapath: scanner state, space buffer memory, value accumulator and output staging.
`default_nettype none
module ptok_dp import ptok_pkg::*; #(
    parameter int SPACE_BUF_DEPTH = SPACE_BUF_DEPTH_DEF,
    parameter int MAX_NEST        = MAX_NEST_DEF,
    parameter int LINE_BITS       = LINE_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    output t_stat           o_stat,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_end_of_source,
    ptok_cfg_if.sink        i_cfg,
    ptok_out_if.source      o_tok
);

    localparam int CNT_W  = $clog2(SPACE_BUF_DEPTH + 1);
    localparam int IDX_W  = (SPACE_BUF_DEPTH > 1) ? $clog2(SPACE_BUF_DEPTH) : 1;
    localparam int NEST_W = $clog2(MAX_NEST + 1);
    localparam logic [CNT_W-1:0]     DEPTH_C    = CNT_W'(SPACE_BUF_DEPTH);
    localparam logic [NEST_W-1:0]    NEST_MAX_C = NEST_W'(MAX_NEST);
    localparam logic [LINE_BITS-1:0] LINE_MAX_C = '1;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_NUMDOT, M_FLOAT,
        M_STRING, M_STRESC, M_COMMENT, M_DOTPEND
    } t_mode;

    function automatic logic [23:0] line24(logic [LINE_BITS-1:0] l);
        logic [32:0] w;
        w = 33'(l);
        return w[23:0];
    endfunction

    logic [23:0]          r_first_line;
    t_mode                r_mode, n_mode;
    logic [3:0]           r_last_kind, n_last_kind;
    logic [LINE_BITS-1:0] r_line;
    logic [LINE_BITS-1:0] r_start_line, n_start_line;
    logic [62:0]          r_acc, n_acc;
    logic                 r_over, n_over;
    logic [NEST_W-1:0]    r_nest, n_nest;
    logic [CNT_W-1:0]     r_sc, n_sc;
    logic                 r_halted, n_halted;
    logic                 r_emitted, n_emitted;
    logic                 r_fresh, n_fresh;
    logic [7:0]           r_char;
    logic                 r_eos;
    logic [7:0]           r_space [SPACE_BUF_DEPTH];
    logic [7:0]           r_rd_data;
    logic [IDX_W-1:0]     r_flush_idx;
    t_item                r_pend;
    logic                 r_pend_valid;
    t_item                r_out;
    logic                 r_out_last;
    logic                 r_out_valid;

    t_item                s_item;
    logic                 s_emit, s_again, s_float2, s_flush, s_wr;
    logic [66:0]          acc10;
    logic                 over_n;
    logic [7:0]           lc_ch;
    logic                 boundary;
    logic [23:0]          sl24, lc24;
    logic [32:0]          fl_ext;
    logic [LINE_BITS-1:0] fresh_line;
    logic [NEST_W-1:0]    nest_dec;
    logic                 out_free, can_emit, emit_now;
    t_item                new_item;

    assign sl24     = line24(r_start_line);
    assign lc24     = line24(r_line);
    assign acc10    = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + 67'(r_char[3:0]);
    assign over_n   = |acc10[66:63];
    assign lc_ch    = is_upper(r_char) ? r_char + 8'd32 : r_char;
    assign boundary = (r_last_kind == K_NONE) || (r_last_kind == K_DOT) ||
                      (r_last_kind == K_COLON) || (r_last_kind == K_COMMENT);
    assign fl_ext     = 33'(r_first_line);
    assign fresh_line = (fl_ext > 33'(LINE_MAX_C)) ? LINE_MAX_C : fl_ext[LINE_BITS-1:0];
    assign nest_dec   = (r_nest != '0) ? r_nest - 1'b1 : r_nest;

    always_comb begin
        n_mode       = r_mode;
        n_last_kind  = r_last_kind;
        n_start_line = r_start_line;
        n_acc        = r_acc;
        n_over       = r_over;
        n_nest       = r_nest;
        n_sc         = r_sc;
        n_halted     = r_halted;
        n_emitted    = r_emitted;
        n_fresh      = r_fresh;
        s_item       = '0;
        s_emit       = 1'b0;
        s_again      = 1'b0;
        s_float2     = 1'b0;
        s_flush      = 1'b0;
        s_wr         = 1'b0;
        if (r_eos) begin
            if (r_halted || r_mode == M_IDLE) begin
                s_emit      = 1'b1;
                s_item      = mk_item(K_END, 8'd0, 1'b0, 1'b1, 1'b1, lc24, '0, E_NONE);
                n_mode      = M_IDLE;
                n_last_kind = K_NONE;
                n_halted    = 1'b0;
                n_sc        = '0;
                n_nest      = '0;
                n_acc       = '0;
                n_over      = 1'b0;
                n_emitted   = 1'b0;
                n_fresh     = 1'b1;
            end else begin
                s_again = 1'b1;
                s_emit  = 1'b1;
                n_mode  = M_IDLE;
                case (r_mode)
                    M_IDENT, M_FLOAT: begin
                        s_item = mk_item((r_mode == M_IDENT) ? K_IDENT : K_FLOAT, 8'd0, 1'b0,
                                         1'b0, 1'b1, sl24, '0, E_NONE);
                        n_last_kind = (r_mode == M_IDENT) ? K_IDENT : K_FLOAT;
                        n_emitted   = 1'b1;
                    end
                    M_NUMBER, M_NUMDOT: begin
                        if (r_over) begin
                            s_item   = mk_item(K_IDENT, 8'd0, 1'b0, 1'b1, 1'b1, sl24, '0,
                                               E_TOO_LARGE);
                            n_halted = 1'b1;
                        end else begin
                            s_item = mk_item(K_NUMBER, 8'd0, 1'b0, 1'b0, 1'b1, sl24, r_acc,
                                             E_NONE);
                            n_last_kind = K_NUMBER;
                            n_mode      = (r_mode == M_NUMDOT) ? M_DOTPEND : M_IDLE;
                        end
                    end
                    M_DOTPEND: begin
                        s_item      = mk_item(K_DOT, CH_DOT, 1'b1, 1'b1, 1'b1, lc24, '0, E_NONE);
                        n_last_kind = K_DOT;
                    end
                    M_STRING, M_STRESC: begin
                        s_item   = mk_item(K_IDENT, 8'd0, 1'b0, 1'b1, 1'b1, sl24, '0,
                                           E_OPEN_STR);
                        n_halted = 1'b1;
                    end
                    default: begin
                        s_item   = mk_item(K_IDENT, 8'd0, 1'b0, 1'b1, 1'b1, sl24, '0,
                                           E_OPEN_CMT);
                        n_halted = 1'b1;
                    end
                endcase
            end
        end else begin
            case (r_mode)
                M_IDENT: begin
                    s_emit = 1'b1;
                    if (is_alpha(r_char) || is_digit(r_char) || r_char == CH_UNDER) begin
                        s_item = mk_item(K_IDENT, lc_ch, 1'b1, 1'b0, 1'b0, sl24, '0, E_NONE);
                    end else begin
                        s_item = mk_item(K_IDENT, 8'd0, 1'b0, 1'b0, 1'b1, sl24, '0, E_NONE);
                        n_emitted   = 1'b1;
                        n_last_kind = K_IDENT;
                        n_mode      = M_IDLE;
                        s_again     = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(r_char)) begin
                        s_emit = 1'b1;
                        s_item = mk_item(K_NUMBER, r_char, 1'b1, 1'b0, 1'b0, sl24, '0, E_NONE);
                        if (r_over || over_n) begin
                            n_over = 1'b1;
                        end else begin
                            n_acc = acc10[62:0];
                        end
                    end else if (r_char == CH_DOT) begin
                        n_mode = M_NUMDOT;
                    end else begin
                        s_emit = 1'b1;
                        n_mode = M_IDLE;
                        if (r_over) begin
                            s_item   = mk_item(K_IDENT, 8'd0, 1'b0, 1'b1, 1'b1, sl24, '0,
                                               E_TOO_LARGE);
                            n_halted = 1'b1;
                        end else begin
                            s_item = mk_item(K_NUMBER, 8'd0, 1'b0, 1'b0, 1'b1, sl24, r_acc,
                                             E_NONE);
                            n_last_kind = K_NUMBER;
                            s_again     = 1'b1;
                        end
                    end
                end
                M_NUMDOT: begin
                    s_emit = 1'b1;
                    if (is_digit(r_char)) begin
                        s_item   = mk_item(K_FLOAT, CH_DOT, 1'b1, 1'b0, 1'b0, sl24, '0, E_NONE);
                        n_mode   = M_FLOAT;
                        s_float2 = 1'b1;
                    end else if (r_over) begin
                        s_item   = mk_item(K_IDENT, 8'd0, 1'b0, 1'b1, 1'b1, sl24, '0,
                                           E_TOO_LARGE);
                        n_halted = 1'b1;
                        n_mode   = M_IDLE;
                    end else begin
                        s_item = mk_item(K_NUMBER, 8'd0, 1'b0, 1'b0, 1'b1, sl24, r_acc, E_NONE);
                        n_last_kind = K_NUMBER;
                        n_mode      = M_DOTPEND;
                        s_again     = 1'b1;
                    end
                end
                M_DOTPEND: begin
                    s_emit      = 1'b1;
                    s_item      = mk_item(K_DOT, CH_DOT, 1'b1, 1'b1, 1'b1, lc24, '0, E_NONE);
                    n_last_kind = K_DOT;
                    n_mode      = M_IDLE;
                    s_again     = 1'b1;
                end
                M_FLOAT: begin
                    s_emit = 1'b1;
                    if (is_digit(r_char)) begin
                        s_item = mk_item(K_FLOAT, r_char, 1'b1, 1'b0, 1'b0, sl24, '0, E_NONE);
                    end else begin
                        s_item = mk_item(K_FLOAT, 8'd0, 1'b0, 1'b0, 1'b1, sl24, '0, E_NONE);
                        n_emitted   = 1'b1;
                        n_last_kind = K_FLOAT;
                        n_mode      = M_IDLE;
                        s_again     = 1'b1;
                    end
                end
                M_STRING: begin
                    if (r_char == CH_QUOTE) begin
                        s_emit = 1'b1;
                        s_item = mk_item(K_STRING, 8'd0, 1'b0, !r_emitted, 1'b1, sl24, '0,
                                         E_NONE);
                        n_last_kind = K_STRING;
                        n_mode      = M_IDLE;
                    end else if (r_char == CH_BSLASH) begin
                        n_mode = M_STRESC;
                    end else begin
                        s_emit = 1'b1;
                        s_item = mk_item(K_STRING, r_char, 1'b1, !r_emitted, 1'b0, sl24, '0,
                                         E_NONE);
                        n_emitted = 1'b1;
                    end
                end
                M_STRESC: begin
                    s_emit = 1'b1;
                    s_item = mk_item(K_STRING, (r_char == CH_LOW_N) ? CH_LF : r_char, 1'b1,
                                     !r_emitted, 1'b0, sl24, '0, E_NONE);
                    n_emitted = 1'b1;
                    n_mode    = M_STRING;
                end
                M_COMMENT: begin
                    if (r_char == CH_LPAREN && r_nest >= NEST_MAX_C) begin
                        s_emit   = 1'b1;
                        s_item   = mk_item(K_IDENT, 8'd0, 1'b0, 1'b1, 1'b1, sl24, '0, E_LIMIT);
                        n_halted = 1'b1;
                        n_mode   = M_IDLE;
                    end else if (r_char == CH_RPAREN && nest_dec == '0) begin
                        s_emit = 1'b1;
                        s_item = mk_item(K_COMMENT, 8'd0, 1'b0, !r_emitted, 1'b1, sl24, '0,
                                         E_NONE);
                        n_nest      = nest_dec;
                        n_sc        = '0;
                        n_last_kind = K_COMMENT;
                        n_mode      = M_IDLE;
                    end else if (is_trim_space(r_char)) begin
                        if (r_emitted) begin
                            if (r_sc >= DEPTH_C) begin
                                s_emit   = 1'b1;
                                s_item   = mk_item(K_IDENT, 8'd0, 1'b0, 1'b1, 1'b1, sl24, '0,
                                                   E_LIMIT);
                                n_halted = 1'b1;
                                n_mode   = M_IDLE;
                            end else begin
                                s_wr = 1'b1;
                                n_sc = r_sc + 1'b1;
                            end
                        end
                    end else if (r_sc != '0) begin
                        s_flush = 1'b1;
                    end else begin
                        s_emit = 1'b1;
                        s_item = mk_item(K_COMMENT, r_char, 1'b1, !r_emitted, 1'b0, sl24, '0,
                                         E_NONE);
                        n_emitted = 1'b1;
                        if (r_char == CH_LPAREN) begin
                            n_nest = r_nest + 1'b1;
                        end else if (r_char == CH_RPAREN) begin
                            n_nest = nest_dec;
                        end
                    end
                end
                default: begin
                    n_start_line = r_line;
                    if (is_space(r_char) || r_char == CH_COMMA) begin
                        n_mode = M_IDLE;
                    end else if (r_char == CH_LPAREN && boundary) begin
                        n_mode    = M_COMMENT;
                        n_nest    = NEST_W'(1);
                        n_emitted = 1'b0;
                        n_sc      = '0;
                    end else if (r_char == CH_DOT || r_char == CH_LPAREN ||
                                 r_char == CH_RPAREN || r_char == CH_COLON) begin
                        s_emit = 1'b1;
                        case (r_char)
                            CH_DOT:    n_last_kind = K_DOT;
                            CH_LPAREN: n_last_kind = K_LPAREN;
                            CH_RPAREN: n_last_kind = K_RPAREN;
                            default:   n_last_kind = K_COLON;
                        endcase
                        s_item = mk_item(n_last_kind, r_char, 1'b1, 1'b1, 1'b1, lc24, '0,
                                         E_NONE);
                    end else if (r_char == CH_QUOTE) begin
                        n_mode    = M_STRING;
                        n_emitted = 1'b0;
                    end else if (is_digit(r_char)) begin
                        s_emit = 1'b1;
                        s_item = mk_item(K_NUMBER, r_char, 1'b1, 1'b1, 1'b0, lc24, '0, E_NONE);
                        n_mode = M_NUMBER;
                        n_acc  = 63'(r_char[3:0]);
                        n_over = 1'b0;
                    end else if (is_alpha(r_char) || r_char == CH_UNDER) begin
                        s_emit = 1'b1;
                        s_item = mk_item(K_IDENT, lc_ch, 1'b1, 1'b1, 1'b0, lc24, '0, E_NONE);
                        n_mode = M_IDENT;
                    end else begin
                        s_emit   = 1'b1;
                        s_item   = mk_item(K_IDENT, 8'd0, 1'b0, 1'b1, 1'b1, lc24, '0,
                                           E_BAD_CHAR);
                        n_halted = 1'b1;
                        n_mode   = M_IDLE;
                    end
                end
            endcase
        end
    end

    // output staging: one item held back so run_last can be set on the final one
    assign out_free = !r_out_valid || o_tok.ready;
    assign can_emit = !r_pend_valid || out_free;
    assign emit_now = (i_cmd.step && s_emit) || i_cmd.flush_emit || i_cmd.float2;

    always_comb begin
        if (i_cmd.flush_emit) begin
            new_item = mk_item(K_COMMENT, r_rd_data, 1'b1, 1'b0, 1'b0, sl24, '0, E_NONE);
        end else if (i_cmd.float2) begin
            new_item = mk_item(K_FLOAT, r_char, 1'b1, 1'b0, 1'b0, sl24, '0, E_NONE);
        end else begin
            new_item = s_item;
        end
    end

    always_comb begin
        o_stat.skip       = r_halted && !r_eos;
        o_stat.emits      = s_emit;
        o_stat.again      = s_again;
        o_stat.float2     = s_float2;
        o_stat.flush      = s_flush;
        o_stat.flush_last = (CNT_W'(r_flush_idx) + 1'b1) == r_sc;
        o_stat.can_emit   = can_emit;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && s_wr) begin
            r_space[r_sc[IDX_W-1:0]] <= r_char;
        end
        r_rd_data <= r_space[r_flush_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= i_char_in;
        end
        if (emit_now) begin
            r_pend <= new_item;
        end
        if (emit_now && r_pend_valid) begin
            r_out      <= r_pend;
            r_out_last <= 1'b0;
        end else if (i_cmd.finish && r_pend_valid) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_line <= 24'd1;
            r_mode       <= M_IDLE;
            r_last_kind  <= K_NONE;
            r_line       <= LINE_BITS'(1);
            r_start_line <= '0;
            r_acc        <= '0;
            r_over       <= 1'b0;
            r_nest       <= '0;
            r_sc         <= '0;
            r_halted     <= 1'b0;
            r_emitted    <= 1'b0;
            r_fresh      <= 1'b1;
            r_eos        <= 1'b0;
            r_flush_idx  <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_first_line <= i_cfg.first_line;
            end
            if (i_cmd.accept) begin
                r_eos <= i_end_of_source;
                if (r_fresh) begin
                    r_line  <= fresh_line;
                    r_fresh <= 1'b0;
                end
            end
            if (i_cmd.step) begin
                r_mode       <= n_mode;
                r_last_kind  <= n_last_kind;
                r_start_line <= n_start_line;
                r_acc        <= n_acc;
                r_over       <= n_over;
                r_nest       <= n_nest;
                r_sc         <= n_sc;
                r_halted     <= n_halted;
                r_emitted    <= n_emitted;
                r_fresh      <= n_fresh;
            end
            if (i_cmd.flush_emit) begin
                if (o_stat.flush_last) begin
                    r_flush_idx <= '0;
                    r_sc        <= '0;
                end else begin
                    r_flush_idx <= r_flush_idx + 1'b1;
                end
            end
            if (i_cmd.finish && !r_eos && r_char == CH_LF && r_line != LINE_MAX_C) begin
                r_line <= r_line + 1'b1;
            end
            if (emit_now) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
            if ((emit_now && r_pend_valid) || (i_cmd.finish && r_pend_valid)) begin
                r_out_valid <= 1'b1;
            end else if (o_tok.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_cfg.ready        = 1'b1;
    assign o_tok.valid        = r_out_valid;
    assign o_tok.token_kind   = r_out.kind;
    assign o_tok.text_char    = r_out.ch;
    assign o_tok.has_char     = r_out.has;
    assign o_tok.token_first  = r_out.first;
    assign o_tok.token_last   = r_out.last;
    assign o_tok.token_line   = r_out.line;
    assign o_tok.number_value = r_out.value;
    assign o_tok.error_code   = r_out.err;
    assign o_tok.run_last     = r_out_last;

endmodule
`default_nettype wire

/* rtl/ptok_ctrl.sv */
// Controller: sequences accept, scan steps, space flush, float digit and finish per byte.
`default_nettype none
module ptok_ctrl import ptok_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_STEP, S_FRD, S_FEMIT, S_FLOAT2, S_FIN} t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_STEP;
                end
            end
            S_STEP: begin
                if (i_stat.skip) begin
                    n_state = S_FIN;
                end else if (i_stat.flush) begin
                    n_state = S_FRD;
                end else if (!i_stat.emits || i_stat.can_emit) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.again) begin
                        n_state = S_STEP;
                    end else if (i_stat.float2) begin
                        n_state = S_FLOAT2;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FRD: n_state = S_FEMIT;
            S_FEMIT: begin
                if (i_stat.can_emit) begin
                    o_cmd.flush_emit = 1'b1;
                    n_state          = i_stat.flush_last ? S_STEP : S_FRD;
                end
            end
            S_FLOAT2: begin
                if (i_stat.can_emit) begin
                    o_cmd.float2 = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.can_emit) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule
`default_nettype wire

/* rtl/prose_language_tokenizer_core.sv */
// Top level: streaming tokenizer for the prose language, byte in, token items out.
//
// Channels: i_src takes one source byte per transfer, or an end-of-source
// marker. o_tok gives token items, one character per transfer, with
// token_first/token_last framing and run_last on the final item caused by
// an input. i_cfg writes first_line; write it only while the block is idle.
// Flow: a byte is taken, then scanned by the controller in scan steps (a
// close and a restart take two steps); each buffered comment space that is
// flushed takes a read and an emit. The output lags the last step by one
// item held back to mark run_last. One byte is in work at a time.
// Reset: synchronous, active low; scanner idle, first_line 1, no output.
// Stalls: when o_tok.ready is low the staging registers fill and the
// controller waits; i_src.ready stays low until the byte is fully done.
// Errors halt the scanner until the next end-of-source, which still emits
// the end token.
`default_nettype none
module prose_language_tokenizer_core import ptok_pkg::*; #(
    parameter int SPACE_BUF_DEPTH = SPACE_BUF_DEPTH_DEF,
    parameter int MAX_NEST        = MAX_NEST_DEF,
    parameter int LINE_BITS       = LINE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ptok_in_if.sink    i_src,
    ptok_cfg_if.sink   i_cfg,
    ptok_out_if.source o_tok
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    ptok_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_src.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptok_dp #(
        .SPACE_BUF_DEPTH (SPACE_BUF_DEPTH),
        .MAX_NEST        (MAX_NEST),
        .LINE_BITS       (LINE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_char_in       (i_src.char_in),
        .i_end_of_source (i_src.end_of_source),
        .i_cfg           (i_cfg),
        .o_tok           (o_tok)
    );

    assign i_src.ready = in_ready;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_src.valid && i_src.ready |=> !i_src.ready)
        else $error("input accepted while previous byte in work");

    a_error_framing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid && o_tok.error_code != E_NONE |->
            o_tok.token_first && o_tok.token_last && !o_tok.has_char)
        else $error("error item framing wrong");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid && o_tok.token_kind == K_END |-> o_tok.run_last)
        else $error("end token not last of its run");
`endif

endmodule
`default_nettype wire
